[design/square_wave_sweep_channel_core_defines.svh]
// Assertion macros used by the checker of the sweep channel.
`ifndef SQUARE_WAVE_SWEEP_CHANNEL_CORE_DEFINES_SVH
`define SQUARE_WAVE_SWEEP_CHANNEL_CORE_DEFINES_SVH

// Implication that takes effect in the same cycle, ignored during reset.
`define SWS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication that takes effect in the following cycle, ignored during reset.
`define SWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication that also holds across reset.
`define SWS_ASSERT_RESET(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sws_pkg.sv]
// ----------------------------------------------------------------------------
// sws_pkg
// Types, codes and helper functions of the square-wave sweep channel.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int CfgDataW  = 11;
  localparam int CfgIndexW = 3;

  // event codes
  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_LENGTH   = 3'd1;
  localparam logic [2:0] FUNC_SWEEP    = 3'd2;
  localparam logic [2:0] FUNC_ENVELOPE = 3'd3;
  localparam logic [2:0] FUNC_TRIGGER  = 3'd4;
  localparam logic [2:0] FUNC_LOAD     = 3'd5;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_SWEEP_CONTROL    = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_DUTY_SELECT      = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_ENVELOPE_CONTROL = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_START_FREQUENCY  = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_LENGTH_ENABLE    = 3'd4;

  localparam logic [6:0] LENGTH_FULL = 7'd64;
  localparam logic [3:0] VOLUME_MAX  = 4'd15;

  typedef struct packed {
    logic [2:0] func;
    logic       frame_phase_odd;
    logic [6:0] new_length;
  } sws_item_t;

  typedef struct packed {
    logic [3:0] sample;
    logic       channel_on;
    logic       dac_on;
  } sws_result_t;

  typedef struct packed {
    logic        overflow;
    logic [10:0] freq;
  } sws_sweep_t;

  // One shift-add of the sweep unit; overflow means the result passed 2047.
  function automatic sws_sweep_t sweep_calc(logic [10:0] shadow, logic [6:0] ctrl);
    logic [11:0] delta;
    logic [11:0] sum;
    sws_sweep_t  r;
    delta = {1'b0, shadow} >> ctrl[2:0];
    sum   = ctrl[3] ? ({1'b0, shadow} - delta) : ({1'b0, shadow} + delta);
    r.overflow = sum[11];
    r.freq     = sum[10:0];
    return r;
  endfunction

  // Tick count of one duty step: 2 * (2048 - f).
  function automatic logic [12:0] period_of(logic [10:0] f);
    logic [11:0] d;
    d = 12'd2048 - {1'b0, f};
    return {d, 1'b0};
  endfunction

  function automatic logic duty_of(logic [1:0] sel, logic [2:0] step);
    logic lvl;
    case (sel)
      2'd0:    lvl = (step == 3'd6);
      2'd1:    lvl = (step >= 3'd6);
      2'd2:    lvl = (step >= 3'd4);
      default: lvl = (step <= 3'd5);
    endcase
    return lvl;
  endfunction

endpackage

[design/sws_in_stage.sv]
// ----------------------------------------------------------------------------
// sws_in_stage
// Input register of the channel; holds one event while the result side stalls.
// ----------------------------------------------------------------------------
module sws_in_stage import sws_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  sws_item_t item,
  output logic      item_stall,
  input  logic      advance,
  output logic      stage_valid,
  output sws_item_t stage_item
);

  logic load;

  assign item_stall = stage_valid && !advance;
  assign load       = !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && item_valid) begin
      stage_item <= item;
    end
  end

endmodule

[design/sws_chan.sv]
// ----------------------------------------------------------------------------
// sws_chan
// Channel state, configuration registers and the per-event update logic.
// ----------------------------------------------------------------------------
module sws_chan import sws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  sws_item_t            stage_item,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output sws_result_t          res
);

  // configuration
  logic [6:0]  sweep_control;
  logic [1:0]  duty_select;
  logic [7:0]  envelope_control;
  logic [10:0] start_frequency;
  logic        length_enable;

  // channel state
  logic        enabled,            enabled_next;
  logic        duty_level,         duty_level_next;
  logic [2:0]  duty_step,          duty_step_next;
  logic [12:0] period_countdown,   period_countdown_next;
  logic [2:0]  envelope_countdown, envelope_countdown_next;
  logic [2:0]  sweep_countdown,    sweep_countdown_next;
  logic [10:0] shadow_frequency,   shadow_frequency_next;
  logic [10:0] current_frequency,  current_frequency_next;
  logic        sweep_active,       sweep_active_next;
  logic [3:0]  volume_level,       volume_level_next;
  logic [6:0]  length_remaining,   length_remaining_next;
  logic [3:0]  held_sample,        held_sample_next;

  logic [2:0]  sweep_period;
  logic [2:0]  sweep_shift;
  logic [2:0]  env_period;
  logic [12:0] period_dec;
  logic [2:0]  step_inc;
  logic [2:0]  sweep_dec;
  logic [2:0]  env_dec;
  logic [10:0] shadow_mid;
  logic        dac_flag;
  sws_sweep_t  sweep_a;
  sws_sweep_t  sweep_b;
  sws_sweep_t  sweep_t;

  assign sweep_period = sweep_control[6:4];
  assign sweep_shift  = sweep_control[2:0];
  assign env_period   = envelope_control[2:0];
  assign dac_flag     = (envelope_control[7:3] != 5'd0);

  assign period_dec = period_countdown - 13'd1;
  assign step_inc   = duty_step + 3'd1;
  assign sweep_dec  = sweep_countdown - 3'd1;
  assign env_dec    = envelope_countdown - 3'd1;

  // sweep clock: a storing pass, then a checking pass on the new shadow value
  assign sweep_a    = sweep_calc(shadow_frequency, sweep_control);
  assign shadow_mid = (!sweep_a.overflow && sweep_shift != 3'd0) ? sweep_a.freq
                                                                 : shadow_frequency;
  assign sweep_b    = sweep_calc(shadow_mid, sweep_control);
  // trigger: checking pass on the start frequency
  assign sweep_t    = sweep_calc(start_frequency, sweep_control);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_control    <= '0;
      duty_select      <= '0;
      envelope_control <= '0;
      start_frequency  <= '0;
      length_enable    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SWEEP_CONTROL:    sweep_control    <= cfg_data[6:0];
        CFG_DUTY_SELECT:      duty_select      <= cfg_data[1:0];
        CFG_ENVELOPE_CONTROL: envelope_control <= cfg_data[7:0];
        CFG_START_FREQUENCY:  start_frequency  <= cfg_data[10:0];
        CFG_LENGTH_ENABLE:    length_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    enabled_next            = enabled;
    duty_level_next         = duty_level;
    duty_step_next          = duty_step;
    period_countdown_next   = period_countdown;
    envelope_countdown_next = envelope_countdown;
    sweep_countdown_next    = sweep_countdown;
    shadow_frequency_next   = shadow_frequency;
    current_frequency_next  = current_frequency;
    sweep_active_next       = sweep_active;
    volume_level_next       = volume_level;
    length_remaining_next   = length_remaining;
    held_sample_next        = held_sample;

    case (stage_item.func)
      FUNC_TICK: begin
        if (period_countdown != 13'd0) begin
          period_countdown_next = period_dec;
          if (period_dec == 13'd0) begin
            period_countdown_next = period_of(current_frequency);
            duty_step_next        = step_inc;
            duty_level_next       = duty_of(duty_select, step_inc);
          end
        end
        held_sample_next = (enabled && duty_level_next) ? volume_level : 4'd0;
      end
      FUNC_LENGTH: begin
        if (length_enable && length_remaining != 7'd0) begin
          length_remaining_next = length_remaining - 7'd1;
          if (length_remaining == 7'd1) begin
            enabled_next = 1'b0;
          end
        end
      end
      FUNC_SWEEP: begin
        sweep_countdown_next = sweep_dec;
        if (sweep_dec == 3'd0) begin
          // a zero period stands for eight counts
          sweep_countdown_next = sweep_period;
          if (sweep_active && sweep_period != 3'd0) begin
            if (sweep_a.overflow) begin
              enabled_next = 1'b0;
            end else if (sweep_shift != 3'd0) begin
              shadow_frequency_next  = sweep_a.freq;
              current_frequency_next = sweep_a.freq;
              period_countdown_next  = period_of(sweep_a.freq);
            end
            if (sweep_b.overflow) begin
              enabled_next = 1'b0;
            end
          end
        end
      end
      FUNC_ENVELOPE: begin
        if (enabled && env_period != 3'd0) begin
          envelope_countdown_next = env_dec;
          if (env_dec == 3'd0) begin
            envelope_countdown_next = env_period;
            if (!envelope_control[3]) begin
              if (volume_level != 4'd0) volume_level_next = volume_level - 4'd1;
            end else begin
              if (volume_level != VOLUME_MAX) volume_level_next = volume_level + 4'd1;
            end
          end
        end
      end
      FUNC_TRIGGER: begin
        enabled_next            = dac_flag;
        current_frequency_next  = start_frequency;
        shadow_frequency_next   = start_frequency;
        period_countdown_next   = period_of(start_frequency);
        envelope_countdown_next = env_period;
        volume_level_next       = envelope_control[7:4];
        if (length_remaining == 7'd0) begin
          length_remaining_next = LENGTH_FULL -
                                  {6'd0, stage_item.frame_phase_odd && length_enable};
        end
        sweep_countdown_next = sweep_period;
        sweep_active_next    = (sweep_period != 3'd0) || (sweep_shift != 3'd0);
        if (sweep_shift != 3'd0 && sweep_t.overflow) begin
          enabled_next = 1'b0;
        end
      end
      FUNC_LOAD: begin
        length_remaining_next = (stage_item.new_length > LENGTH_FULL) ? LENGTH_FULL
                                                                      : stage_item.new_length;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled            <= 1'b0;
      duty_level         <= 1'b0;
      duty_step          <= '0;
      period_countdown   <= '0;
      envelope_countdown <= '0;
      sweep_countdown    <= '0;
      shadow_frequency   <= '0;
      current_frequency  <= '0;
      sweep_active       <= 1'b0;
      volume_level       <= '0;
      length_remaining   <= LENGTH_FULL;
      held_sample        <= '0;
    end else if (fire) begin
      enabled            <= enabled_next;
      duty_level         <= duty_level_next;
      duty_step          <= duty_step_next;
      period_countdown   <= period_countdown_next;
      envelope_countdown <= envelope_countdown_next;
      sweep_countdown    <= sweep_countdown_next;
      shadow_frequency   <= shadow_frequency_next;
      current_frequency  <= current_frequency_next;
      sweep_active       <= sweep_active_next;
      volume_level       <= volume_level_next;
      length_remaining   <= length_remaining_next;
      held_sample        <= held_sample_next;
    end
  end

  assign res.sample     = held_sample_next;
  assign res.channel_on = enabled_next;
  assign res.dac_on     = dac_flag;

endmodule

[design/sws_out_reg.sv]
// ----------------------------------------------------------------------------
// sws_out_reg
// Result register; holds the transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module sws_out_reg import sws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  sws_result_t res,
  input  logic        result_stall,
  output logic        result_valid,
  output sws_result_t result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res;
    end
  end

endmodule

[design/square_wave_sweep_channel_core.sv]
// ----------------------------------------------------------------------------
// square_wave_sweep_channel_core
// Square-wave sound channel with frequency sweep, envelope and length counter.
// ----------------------------------------------------------------------------
// Usage:
//   item/item_valid/item_stall carry events (tick, length clock, sweep clock,
//   envelope clock, trigger, length load). Every event gives one transaction
//   on result/result_valid/result_stall: sample level, channel enable, DAC flag.
//   Registers are written through cfg_write/cfg_index/cfg_data; the user must
//   write them only while idle, which the block does not enforce.
//   start_frequency takes effect at the next trigger.
// Path: an accepted event waits in the input register while the state update
//   runs on it, and its result is registered in the result register.
// Throughput: one event per cycle while no stalled result blocks the output.
// Reset clears both registers, the configuration and the channel state
//   (length counter starts at 64).
// While result_stall holds a waiting result, one more event is taken into the
//   input register; after that item_stall rises until the result drains.
// ----------------------------------------------------------------------------
module square_wave_sweep_channel_core import sws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  sws_item_t            item,
  output logic                 item_stall,
  output logic                 result_valid,
  output sws_result_t          result,
  input  logic                 result_stall,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  logic        advance;
  logic        fire;
  logic        stage_valid;
  sws_item_t   stage_item;
  sws_result_t res;

  // result slot is free or being emptied this cycle
  assign advance = !result_valid || !result_stall;
  assign fire    = stage_valid && advance;

  sws_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .item_stall  (item_stall),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  sws_chan u_chan (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .stage_item (stage_item),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res        (res)
  );

  sws_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .res          (res),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

[design/sws_checker.sv]
// ----------------------------------------------------------------------------
// sws_checker
// Port-level checks of the sweep channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "square_wave_sweep_channel_core_defines.svh"

module sws_checker import sws_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_stall,
  input logic                 result_valid,
  input sws_result_t          result,
  input logic                 result_stall
);

  `SWS_ASSERT_RESET(a_reset_empty, clk, rst, !result_valid, "result valid after reset")
  `SWS_ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall, result_valid, "stalled result dropped")
  `SWS_ASSERT_NEXT(a_result_stable, clk, rst, result_valid && result_stall, $stable(result), "stalled result changed")
  `SWS_ASSERT_NOW(a_stall_cause, clk, rst, item_stall, result_valid && result_stall, "input stalled with free output")

endmodule

bind square_wave_sweep_channel_core sws_checker u_sws_checker (.*);
